// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/thpl_pkg.sv =====
// Shared types and constants of the tagged header parser.
package thpl_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_BADARG   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Header format constants
  localparam int unsigned MIN_PKT_BYTES = 12;  // smallest legal packet
  localparam int unsigned BYTES_PER_TAG = 12;  // offset + tag + 4 value bytes
  localparam int unsigned HDR_PER_TAG   = 8;   // offset word + tag word
  localparam int unsigned ALIGN_BYTES   = 4;

  // Stream layout
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned USR_ACTION = 0;
  localparam int unsigned USR_FIRST  = 1;

  // Controller to datapath
  typedef struct packed {
    logic parse;   // header word accepted
    logic lookup;  // lookup request accepted, start tag search
    logic finish;  // lookup read data valid, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or draining this cycle
  } stat_t;

endpackage

// ===== src/thpl_ctrl.sv =====
// Request sequencer: accepts requests and steps lookups through the table read.
module thpl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  input  thpl_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output thpl_pkg::cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && in_action_i) state_d = S_LOOK;
      S_LOOK: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o.parse  = accept && !in_action_i;
  assign cmd_o.lookup = accept && in_action_i;
  assign cmd_o.finish = (state_q == S_LOOK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/thpl_datapath.sv =====
// Header checks, entry tables, tag search and result register.
module thpl_datapath #(
  parameter int unsigned MAX_TAGS = 16,
  parameter int unsigned NW       = 5,
  parameter int unsigned IW       = 4,
  parameter int unsigned PW       = 5,
  parameter int unsigned OW       = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  thpl_pkg::cmd_t            cmd_i,
  output thpl_pkg::stat_t           stat_o,
  input  logic                      first_i,
  input  logic [31:0]               word_i,
  input  logic [15:0]               pbytes_i,
  input  logic [31:0]               query_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [OW-1:0]             out_data_o,
  output logic [thpl_pkg::OUT_USER_W-1:0] out_status_o
);

  // Control state
  logic [NW-1:0] tag_total_q, tag_total_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   pl_q, pl_d;
  logic          rdy_q, rdy_d;
  // Running previous offset / tag of the header in progress
  logic [15:0]   prev_off_q, prev_off_d;
  logic [31:0]   prev_tag_q, prev_tag_d;

  // Entry tables
  logic [15:0] off_mem_q [MAX_TAGS];
  logic [15:0] len_mem_q [MAX_TAGS];
  logic [31:0] tag_q     [MAX_TAGS];

  logic          off_we, len_we, tag_we;
  logic [IW-1:0] off_wa, len_wa, tag_wa;
  logic [15:0]   off_wd, len_wd;

  // Parse result
  logic       pres_v;
  logic [1:0] pres_st;

  // First-word checks
  logic [NW-1:0] n_in;
  logic [16:0]   n12_in;
  logic [15:0]   n8_in;
  logic          pb_bad, first_fmt;

  assign n_in   = word_i[NW-1:0];
  assign n12_in = 17'(n_in) * 17'(thpl_pkg::BYTES_PER_TAG);
  assign n8_in  = 16'(n_in) * 16'(thpl_pkg::HDR_PER_TAG);
  assign pb_bad = (pbytes_i < 16'(thpl_pkg::MIN_PKT_BYTES))
               || (pbytes_i[1:0] != 2'b00);
  assign first_fmt = (word_i == 32'd0) || (word_i > 32'(MAX_TAGS))
                  || (n12_in > {1'b0, pbytes_i}) || (n8_in >= pbytes_i);

  // Offset and tag words
  logic [15:0]   n8_cur;
  logic [32:0]   off_abs;
  logic          off_err, in_off, tag_err, tag_last;
  logic [PW-1:0] tag_i;

  assign n8_cur   = 16'(tag_total_q) * 16'(thpl_pkg::HDR_PER_TAG);
  assign off_abs  = {1'b0, word_i} + 33'(n8_cur);
  assign off_err  = (off_abs[1:0] != 2'b00) || (off_abs < 33'(prev_off_q))
                 || (off_abs > 33'(pl_q));
  assign in_off   = pos_q < PW'(tag_total_q);
  assign tag_i    = pos_q - PW'(tag_total_q);
  assign tag_err  = (tag_i != '0) && (word_i <= prev_tag_q);
  assign tag_last = tag_i == (PW'(tag_total_q) - PW'(1));

  always_comb begin
    tag_total_d = tag_total_q;
    pos_d       = pos_q;
    pl_d        = pl_q;
    rdy_d       = rdy_q;
    prev_off_d  = prev_off_q;
    prev_tag_d  = prev_tag_q;
    off_we = 1'b0; off_wa = '0; off_wd = '0;
    len_we = 1'b0; len_wa = '0; len_wd = '0;
    tag_we = 1'b0; tag_wa = '0;
    pres_v  = 1'b0;
    pres_st = thpl_pkg::ST_OK;
    if (cmd_i.parse) begin
      if (first_i) begin
        pl_d        = pbytes_i;
        rdy_d       = 1'b0;
        pos_d       = '0;
        tag_total_d = '0;
        if (pb_bad) begin
          pres_v  = 1'b1;
          pres_st = thpl_pkg::ST_BADARG;
        end else if (first_fmt) begin
          pres_v  = 1'b1;
          pres_st = thpl_pkg::ST_FORMAT;
        end else begin
          tag_total_d = n_in;
          pos_d       = PW'(1);
          off_we      = 1'b1;
          off_wd      = n8_in;
          prev_off_d  = n8_in;
        end
      end else if (pos_q != '0) begin
        if (in_off) begin
          if (off_err) begin
            pres_v  = 1'b1;
            pres_st = thpl_pkg::ST_FORMAT;
            pos_d   = '0;
          end else begin
            off_we     = 1'b1;
            off_wa     = pos_q[IW-1:0];
            off_wd     = off_abs[15:0];
            len_we     = 1'b1;
            len_wa     = IW'(pos_q - PW'(1));
            len_wd     = off_abs[15:0] - prev_off_q;
            prev_off_d = off_abs[15:0];
            pos_d      = pos_q + PW'(1);
          end
        end else begin
          if (tag_err) begin
            pres_v  = 1'b1;
            pres_st = thpl_pkg::ST_FORMAT;
            pos_d   = '0;
          end else begin
            tag_we     = 1'b1;
            tag_wa     = tag_i[IW-1:0];
            prev_tag_d = word_i;
            if (tag_last) begin
              // last entry runs to the end of the packet
              len_we  = 1'b1;
              len_wa  = tag_i[IW-1:0];
              len_wd  = pl_q - prev_off_q;
              rdy_d   = 1'b1;
              pos_d   = '0;
              pres_v  = 1'b1;
              pres_st = thpl_pkg::ST_OK;
            end else begin
              pos_d = pos_q + PW'(1);
            end
          end
        end
      end
    end
  end

  // Tag search over the current header's entries, lowest index wins
  logic          hit_any;
  logic [IW-1:0] hit_idx;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = MAX_TAGS - 1; i >= 0; i--) begin
      if ((NW'(unsigned'(i)) < tag_total_q) && (tag_q[i] == query_i)) begin
        hit_any = 1'b1;
        hit_idx = IW'(unsigned'(i));
      end
    end
  end

  // Table writes and registered lookup read
  logic [15:0] off_rd_q, len_rd_q;
  logic        lk_found_q, lk_ready_q;

  always_ff @(posedge clk_i) begin
    if (off_we) off_mem_q[off_wa] <= off_wd;
    if (len_we) len_mem_q[len_wa] <= len_wd;
    if (cmd_i.lookup) begin
      off_rd_q <= off_mem_q[hit_idx];
      len_rd_q <= len_mem_q[hit_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_q[tag_wa] <= word_i;
    prev_off_q <= prev_off_d;
    prev_tag_q <= prev_tag_d;
    if (cmd_i.lookup) begin
      lk_found_q <= hit_any && rdy_q;
      lk_ready_q <= rdy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_total_q <= '0;
      pos_q       <= '0;
      pl_q        <= '0;
      rdy_q       <= 1'b0;
    end else begin
      tag_total_q <= tag_total_d;
      pos_q       <= pos_d;
      pl_q        <= pl_d;
      rdy_q       <= rdy_d;
    end
  end

  // Result register
  logic          out_valid_q;
  logic [1:0]    out_st_q;
  logic [15:0]   out_off_q, out_len_q;
  logic [NW-1:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pres_v || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pres_v) begin
      out_st_q  <= pres_st;
      out_off_q <= '0;
      out_len_q <= '0;
      out_cnt_q <= (pres_st == thpl_pkg::ST_OK) ? tag_total_q : '0;
    end else if (cmd_i.finish) begin
      if (!lk_ready_q) begin
        out_st_q  <= thpl_pkg::ST_BADARG;
        out_off_q <= '0;
        out_len_q <= '0;
        out_cnt_q <= '0;
      end else if (lk_found_q) begin
        out_st_q  <= thpl_pkg::ST_OK;
        out_off_q <= off_rd_q;
        out_len_q <= len_rd_q;
        out_cnt_q <= tag_total_q;
      end else begin
        out_st_q  <= thpl_pkg::ST_NOTFOUND;
        out_off_q <= '0;
        out_len_q <= '0;
        out_cnt_q <= tag_total_q;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_st_q;
  assign out_data_o      = OW'({out_cnt_q, out_len_q, out_off_q});

endmodule

// ===== src/tagged_header_parse_lookup.sv =====
// Top level of the tagged message header parser with tag lookup.
// Header errors/completion are registered as results; a lookup first passes the read registers.
// Throughput: one header word per cycle while the output is free; a lookup blocks during its read.
// The tag search compares the header's tags in parallel; the hit index then addresses the table.
// Reset (rst_ni low, asynchronous) clears the header-in-progress, ready flag and result valid;
// entry tables are not cleared, entries are only read once the current header wrote them.
module tagged_header_parse_lookup #(
  parameter int unsigned MAX_TAGS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request side
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] data_word, [47:32] packet_bytes, [79:48] query_tag
  input  logic [thpl_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [0] action, [1] first_word
  input  logic [thpl_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  // result side
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [15:0] field_offset, [31:16] field_length, [32+:CW] entry_count, rest zero
  output logic [((32 + $clog2(MAX_TAGS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [thpl_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);

  // Count width (0..MAX_TAGS), table index width, header word position width
  localparam int unsigned NW = $clog2(MAX_TAGS + 1);
  localparam int unsigned IW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int unsigned PW = $clog2(2 * MAX_TAGS);
  localparam int unsigned OW = ((32 + NW + 7) / 8) * 8;

  thpl_pkg::cmd_t  cmd;
  thpl_pkg::stat_t stat;

  // Sequencer: header words handled on acceptance, two-step lookups,
  // holds off new requests while a result is stuck at the output.
  thpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_action_i(s_axis_tuser_i[thpl_pkg::USR_ACTION]),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  // Datapath: header checks, offset/length tables, tag registers,
  // parallel tag compare and the result register.
  thpl_datapath #(
    .MAX_TAGS(MAX_TAGS),
    .NW      (NW),
    .IW      (IW),
    .PW      (PW),
    .OW      (OW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .first_i     (s_axis_tuser_i[thpl_pkg::USR_FIRST]),
    .word_i      (s_axis_tdata_i[31:0]),
    .pbytes_i    (s_axis_tdata_i[47:32]),
    .query_i     (s_axis_tdata_i[79:48]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_status_o(m_axis_tuser_o)
  );

endmodule

// ===== src/thpl_checker.sv =====
// Port-level checker for the tagged header parser, bound to the top level.
`include "assert_macros.svh"

module thpl_checker #(
  parameter int unsigned MAX_TAGS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [thpl_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [((32 + $clog2(MAX_TAGS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  input logic [thpl_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);

  localparam int unsigned NW = $clog2(MAX_TAGS + 1);

  // stalled result holds
  `ASSERT_CLK(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)), "result changed while stalled")

  // only a found lookup carries offset and length
  `ASSERT_CLK(a_zero_fields, (m_axis_tvalid_o && (m_axis_tuser_o != thpl_pkg::ST_OK)) |-> (m_axis_tdata_o[31:0] == 32'd0), "nonzero offset/length on non-success result")

  // errors report no entries
  `ASSERT_CLK(a_err_count, (m_axis_tvalid_o && ((m_axis_tuser_o == thpl_pkg::ST_FORMAT) || (m_axis_tuser_o == thpl_pkg::ST_BADARG))) |-> (m_axis_tdata_o[32 +: NW] == '0), "entry count on error result")

  // success always refers to a header with at least one tag
  `ASSERT_NEVER(a_ok_count, m_axis_tvalid_o && (m_axis_tuser_o == thpl_pkg::ST_OK) && (m_axis_tdata_o[32 +: NW] == '0), "success with zero entries")

  // a lookup blocks the next request for its table read
  `ASSERT_CLK(a_lookup_busy, (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[thpl_pkg::USR_ACTION]) |=> !s_axis_tready_o, "request taken during lookup")

endmodule

bind tagged_header_parse_lookup thpl_checker #(.MAX_TAGS(MAX_TAGS)) u_thpl_checker (.*);
